// File: sv/weekly_alarm_table_relay_timer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the weekly alarm relay timer
// Clocked assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef WEEKLY_ALARM_TABLE_RELAY_TIMER_DEFINES_SVH
`define WEEKLY_ALARM_TABLE_RELAY_TIMER_DEFINES_SVH

`ifndef SYNTHESIS
// Check on every rising edge outside reset.
`define WATRT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every rising edge, reset included.
`define WATRT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define WATRT_ASSERT(label, prop, msg)
`define WATRT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// File: sv/watrt_pkg.sv
// ----------------------------------------------------------------------------
// watrt_pkg
// Shared types and codes of the weekly alarm relay timer.
// ----------------------------------------------------------------------------
`default_nettype none

package watrt_pkg;

  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int WDAY_W = 3;
  localparam int ONM_W  = 8;
  localparam int SLOT_W = 6;
  localparam int STAT_W = 2;
  localparam int CD_W   = 14;
  localparam int TIME_W = HOUR_W + MIN_W + WDAY_W;
  localparam int LAST_W = TIME_W + 1;

  localparam int SECONDS_PER_MINUTE = 60;

  // command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_TIME   = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

  // classified operations handed from front to back
  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_MATCH  = 3'd2;
  localparam logic [2:0] OP_SKIP   = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  // "no time seen yet"; a packed time never reaches it
  localparam logic [LAST_W-1:0] NO_TIME = '1;

  typedef struct packed {
    logic [2:0]        op;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [WDAY_W-1:0] weekday;
    logic [ONM_W-1:0]  on_minutes;
  } item_t;

  typedef struct packed {
    logic              act;
    logic [ONM_W-1:0]  on_minutes;
    logic [WDAY_W-1:0] weekday;
    logic [MIN_W-1:0]  minute;
    logic [HOUR_W-1:0] hour;
  } entry_t;

  typedef struct packed {
    logic  full;
    logic  empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: sv/watrt_front.sv
// ----------------------------------------------------------------------------
// watrt_front
// Accepts commands, classifies them and filters repeated time updates.
// ----------------------------------------------------------------------------
`default_nettype none

module watrt_front
  import watrt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [1:0]        cmd,
  input  wire logic [HOUR_W-1:0] hour,
  input  wire logic [MIN_W-1:0]  minute,
  input  wire logic [WDAY_W-1:0] weekday,
  input  wire logic [ONM_W-1:0]  on_minutes,
  input  wire q_stat_t           q_stat,
  input  wire logic              clearing,
  output logic                   busy,
  output logic                   push,
  output item_t                  item
);

  logic [LAST_W-1:0] last_time;
  logic [LAST_W-1:0] now;

  assign now  = {1'b0, weekday, minute, hour};
  assign busy = q_stat.full | clearing;
  assign push = start & ~busy;

  always_comb begin
    item.hour       = hour;
    item.minute     = minute;
    item.weekday    = weekday;
    item.on_minutes = on_minutes;
    case (cmd)
      CMD_ADD:    item.op = OP_ADD;
      CMD_REMOVE: item.op = OP_REMOVE;
      CMD_TIME:   item.op = (now == last_time) ? OP_SKIP : OP_MATCH;
      default:    item.op = OP_TICK;
    endcase
  end

  // track the last distinct time in acceptance order
  always_ff @(posedge clk) begin
    if (rst) begin
      last_time <= NO_TIME;
    end else if (push && cmd == CMD_TIME) begin
      last_time <= now;
    end
  end

endmodule

`default_nettype wire

// File: sv/watrt_queue.sv
// ----------------------------------------------------------------------------
// watrt_queue
// Two-entry queue of classified transactions between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module watrt_queue
  import watrt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  input  wire logic  pop,
  output item_t      head,
  output q_stat_t    q_stat
);

  item_t       slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign head         = slots[rd_ptr];
  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// File: sv/watrt_back.sv
// ----------------------------------------------------------------------------
// watrt_back
// Alarm table memory, scan engine, relay countdown and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "weekly_alarm_table_relay_timer_defines.svh"

module watrt_back
  import watrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire item_t          head,
  input  wire q_stat_t        q_stat,
  output logic                pop,
  output logic                clearing,
  output logic                done,
  output logic                relay_drive,
  output logic [STAT_W-1:0]   status,
  output logic [SLOT_W-1:0]   slot
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW:0]   DEPTH_C = (AW+1)'(TABLE_DEPTH);
  localparam logic [AW:0]   CLR_END = (AW+1)'(TABLE_DEPTH - 1);
  localparam logic [AW-1:0] LAST_C  = AW'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_data;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] wa;
  entry_t        wd;

  logic [1:0]    state, state_next;
  logic [AW:0]   idx, idx_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_idx, pend_idx_next;
  logic          found, found_next;
  item_t         cur, cur_next;
  logic [CD_W-1:0] cd, cd_next;
  logic          finish;
  logic [STAT_W-1:0] res_status;
  logic [SLOT_W-1:0] res_slot;
  logic          issuing;
  logic          hm_hit;
  logic          time_hit;
  logic          last_one;
  logic [CD_W-1:0] cd_load;

  // memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

  assign clearing = (state == S_CLEAR);
  assign issuing  = (state == S_SCAN) && (idx < DEPTH_C);
  assign rd_addr  = idx[AW-1:0];
  assign hm_hit   = rd_data.act && rd_data.hour == cur.hour && rd_data.minute == cur.minute;
  assign time_hit = hm_hit && rd_data.weekday == cur.weekday;
  assign last_one = (pend_idx == LAST_C);
  assign cd_load  = CD_W'(rd_data.on_minutes) * CD_W'(SECONDS_PER_MINUTE);

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    pend_next     = 1'b0;
    pend_idx_next = pend_idx;
    found_next    = found;
    cur_next      = cur;
    cd_next       = cd;
    pop           = 1'b0;
    finish        = 1'b0;
    res_status    = STAT_OK;
    res_slot      = '0;
    we            = 1'b0;
    wa            = pend_idx;
    wd            = rd_data;
    case (state)
      S_CLEAR: begin
        we       = 1'b1;
        wa       = idx[AW-1:0];
        wd       = '0;
        idx_next = idx + (AW+1)'(1);
        if (idx == CLR_END) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          case (head.op)
            OP_TICK: begin
              finish = 1'b1;
              if (cd != '0) begin
                cd_next = cd - CD_W'(1);
              end
            end
            OP_SKIP: begin
              finish = 1'b1;
            end
            default: begin
              cur_next   = head;
              idx_next   = '0;
              found_next = 1'b0;
              state_next = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        pend_next     = issuing;
        pend_idx_next = idx[AW-1:0];
        if (issuing) begin
          idx_next = idx + (AW+1)'(1);
        end
        if (pend) begin
          case (cur.op)
            OP_ADD: begin
              if (!rd_data.act) begin
                we          = 1'b1;
                wd.act      = 1'b1;
                wd.on_minutes = cur.on_minutes;
                wd.weekday  = cur.weekday;
                wd.minute   = cur.minute;
                wd.hour     = cur.hour;
                finish      = 1'b1;
                res_slot    = SLOT_W'(pend_idx);
              end else if (last_one) begin
                finish      = 1'b1;
                res_status  = STAT_FULL;
              end
            end
            OP_REMOVE: begin
              if (hm_hit) begin
                we         = 1'b1;
                wd.act     = 1'b0;
                found_next = 1'b1;
              end
              if (last_one) begin
                finish     = 1'b1;
                res_status = (found || hm_hit) ? STAT_OK : STAT_NOTFOUND;
              end
            end
            default: begin
              if (time_hit) begin
                cd_next  = cd_load;
                finish   = 1'b1;
                res_slot = SLOT_W'(pend_idx);
              end else if (last_one) begin
                finish   = 1'b1;
              end
            end
          endcase
        end
        if (finish) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      idx         <= '0;
      pend        <= 1'b0;
      found       <= 1'b0;
      cd          <= '0;
      done        <= 1'b0;
      relay_drive <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      pend        <= pend_next;
      found       <= found_next;
      cd          <= cd_next;
      done        <= finish;
      if (finish) begin
        relay_drive <= (cd_next != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx <= pend_idx_next;
    cur      <= cur_next;
    if (finish) begin
      status <= res_status;
      slot   <= res_slot;
    end
  end

  `WATRT_ASSERT(a_pop_nonempty, pop |-> !q_stat.empty, "pop from empty queue")
  `WATRT_ASSERT(a_match_no_write, (state == S_SCAN && cur.op == OP_MATCH) |-> !we, "scan wrote")
  `WATRT_ASSERT(a_relay_tracks, done |-> (relay_drive == (cd != '0)), "relay off countdown")
  `WATRT_ASSERT(a_err_slot_zero, (done && status != STAT_OK) |-> (slot == '0), "bad slot")

endmodule

`default_nettype wire

// File: sv/weekly_alarm_table_relay_timer.sv
// ----------------------------------------------------------------------------
// weekly_alarm_table_relay_timer
// Weekly alarm table with one relay countdown, front/queue/back organization.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                     Payload
// command   in         start high while busy low     cmd, hour, minute, weekday, on_minutes
// result    out        done strobe, one cycle        relay_drive, status, slot
//
// Add, remove and time updates scan the table one entry per cycle through the
// single read port; add stops at the first free entry and match at the first
// hit. Ticks and repeated time updates finish without a scan. After reset a
// clearing pass writes every table entry to zero and holds busy high; busy
// also rises while the two-entry queue is full. done cannot be held off by
// the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module weekly_alarm_table_relay_timer
  import watrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        cmd,
  input  wire logic [HOUR_W-1:0] hour,
  input  wire logic [MIN_W-1:0]  minute,
  input  wire logic [WDAY_W-1:0] weekday,
  input  wire logic [ONM_W-1:0]  on_minutes,
  output logic                   done,
  output logic                   relay_drive,
  output logic [STAT_W-1:0]      status,
  output logic [SLOT_W-1:0]      slot
);

  item_t   push_item;
  item_t   head;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  logic    clearing;

  // classify and filter repeated times in arrival order
  watrt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .hour       (hour),
    .minute     (minute),
    .weekday    (weekday),
    .on_minutes (on_minutes),
    .q_stat     (q_stat),
    .clearing   (clearing),
    .busy       (busy),
    .push       (push),
    .item       (push_item)
  );

  // hold up to two classified transactions while the back scans
  watrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // scan the table, advance the countdown, drive the result strobe
  watrt_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .clearing    (clearing),
    .done        (done),
    .relay_drive (relay_drive),
    .status      (status),
    .slot        (slot)
  );

endmodule

`default_nettype wire
